>>> sv/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpfd_pkg;

  typedef enum logic [1:0] {
    PH_LEN   = 2'd0,
    PH_MAGIC = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TOO_LONG  = 2'd1;
  localparam logic [1:0] ERR_TOO_SHORT = 2'd2;
  localparam logic [1:0] ERR_BAD_MAGIC = 2'd3;

  localparam logic [31:0] MIN_FRAME_LEN   = 32'd8;
  localparam logic [31:0] MAGIC_LEN       = 32'd4;
  localparam logic [31:0] MAX_LEN_DEFAULT = 32'd65536;

  // magic sequence, one byte per position
  function automatic logic [7:0] magic_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = 8'h56;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'h53;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  data_byte;
    logic [31:0] frame_len;
    logic        last_of_frame;
    logic [1:0]  error_code;
  } result_t;

  // handoff from the input register to the parser
  typedef struct packed {
    logic       valid;
    logic [7:0] stream_byte;
  } in_item_t;

endpackage

`default_nettype wire

>>> sv/lpfd_if.sv
// ----------------------------------------------------------------------------
// lpfd channel interfaces
// Valid/ready channels for input bytes, results and the config write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  data_byte;
  logic [31:0] frame_len;
  logic        last_of_frame;
  logic [1:0]  error_code;
  modport source (output valid, output result_kind, output data_byte, output frame_len,
                  output last_of_frame, output error_code, input ready);
  modport sink   (input valid, input result_kind, input data_byte, input frame_len,
                  input last_of_frame, input error_code, output ready);
endinterface

interface lpfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] max_frame_len;
  modport source (output valid, output max_frame_len, input ready);
  modport sink   (input valid, input max_frame_len, output ready);
endinterface

`default_nettype wire

>>> sv/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// lpfd_in_stage
// Input register; holds one stream byte until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              up_valid,
  output      logic              up_ready,
  input  wire logic [7:0]        up_byte,
  output      lpfd_pkg::in_item_t item,
  input  wire logic              take
);
  import lpfd_pkg::*;

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign up_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (up_ready) begin
      valid_nxt = up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      byte_r <= up_byte;
    end
  end

  assign item.valid       = valid_r;
  assign item.stream_byte = byte_r;

endmodule

`default_nettype wire

>>> sv/lpfd_parser.sv
// ----------------------------------------------------------------------------
// lpfd_parser
// Frame parser state, length/magic checks and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfd_parser (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lpfd_pkg::in_item_t item,
  output      logic               take,
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_data,
  output      logic               res_valid,
  output      lpfd_pkg::result_t  res,
  input  wire logic               res_ready
);
  import lpfd_pkg::*;

  phase_t      phase_r,   phase_nxt;
  logic [1:0]  idx_r,     idx_nxt;
  logic [31:0] len_r,     len_nxt;
  logic [31:0] remain_r,  remain_nxt;
  logic [1:0]  err_r,     err_nxt;
  logic [31:0] max_r;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_r;

  logic        step;
  logic        emit;
  result_t     res_d;
  logic [7:0]  b;
  logic        magic_ok;
  logic [31:0] len_full;
  logic [31:0] len_part;
  logic [31:0] remain_dec;

  assign b    = item.stream_byte;
  assign take = item.valid && (!out_valid_r || res_ready);
  assign step = take && (err_r == ERR_NONE);

  assign magic_ok   = (b == magic_byte(idx_r));
  assign len_full   = {b, len_r[23:0]};
  assign remain_dec = (remain_r != 32'd0) ? remain_r - 32'd1 : remain_r;

  // little-endian gather of the length bytes
  always_comb begin
    len_part = len_r;
    case (idx_r)
      2'd0:    len_part = {24'd0, b};
      2'd1:    len_part = {len_r[31:16], b, len_r[7:0]};
      2'd2:    len_part = {len_r[31:24], b, len_r[15:0]};
      default: len_part = len_full;
    endcase
  end

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    len_nxt    = len_r;
    remain_nxt = remain_r;
    err_nxt    = err_r;
    if (step) begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (!magic_ok) begin
            err_nxt = ERR_BAD_MAGIC;
          end else if (idx_r != 2'd3) begin
            idx_nxt = idx_r + 2'd1;
          end else begin
            phase_nxt  = PH_BODY;
            idx_nxt    = 2'd0;
            remain_nxt = len_r - MAGIC_LEN;
          end
        end
        PH_BODY: begin
          remain_nxt = remain_dec;
          if (remain_dec == 32'd0) begin
            phase_nxt = PH_LEN;
            len_nxt   = 32'd0;
          end
        end
        default: begin
          len_nxt   = len_part;
          phase_nxt = PH_LEN;
          if (idx_r != 2'd3) begin
            idx_nxt = idx_r + 2'd1;
          end else begin
            idx_nxt = 2'd0;
            if (len_full > max_r) begin
              err_nxt = ERR_TOO_LONG;
            end else if (len_full < MIN_FRAME_LEN) begin
              err_nxt = ERR_TOO_SHORT;
            end else begin
              phase_nxt = PH_MAGIC;
            end
          end
        end
      endcase
    end
  end

  // result for this item
  always_comb begin
    emit  = 1'b0;
    res_d = '0;
    if (step) begin
      unique case (phase_r)
        PH_MAGIC: begin
          if (!magic_ok) begin
            emit             = 1'b1;
            res_d.result_kind = KIND_ERROR;
            res_d.error_code  = ERR_BAD_MAGIC;
          end else if (idx_r == 2'd3) begin
            emit             = 1'b1;
            res_d.result_kind = KIND_START;
            res_d.frame_len   = len_r;
          end
        end
        PH_BODY: begin
          emit               = 1'b1;
          res_d.result_kind   = KIND_BYTE;
          res_d.data_byte     = b;
          res_d.last_of_frame = (remain_dec == 32'd0);
        end
        default: begin
          if (idx_r == 2'd3) begin
            if (len_full > max_r) begin
              emit             = 1'b1;
              res_d.result_kind = KIND_ERROR;
              res_d.error_code  = ERR_TOO_LONG;
            end else if (len_full < MIN_FRAME_LEN) begin
              emit             = 1'b1;
              res_d.result_kind = KIND_ERROR;
              res_d.error_code  = ERR_TOO_SHORT;
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = emit;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEN;
      idx_r       <= 2'd0;
      len_r       <= 32'd0;
      remain_r    <= 32'd0;
      err_r       <= ERR_NONE;
      max_r       <= MAX_LEN_DEFAULT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      len_r       <= len_nxt;
      remain_r    <= remain_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        max_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      out_r <= res_d;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

`default_nettype wire

>>> sv/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream into length-prefixed frames with a magic check.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle and sustains that rate under no output
// stall; each byte passes an input register and then a result register,
// which holds its result until the receiver takes it. Per byte the parser
// does at most two 32-bit compares and one 32-bit subtract, set by the frame
// state register loop. Length bytes and the first three magic bytes give no
// result unless a length or magic check fails; the fourth magic byte gives a
// frame start, each body byte one frame byte.
// Any error is reported once and all later bytes are dropped until reset.
// The maximum length may be written at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire logic clk,
  input  wire logic rst_n,
  lpfd_in_if.sink   in_if,
  lpfd_out_if.source out_if,
  lpfd_cfg_if.sink  cfg_if
);
  import lpfd_pkg::*;

  in_item_t item;
  logic     take;
  logic     res_valid;
  result_t  res;

  assign cfg_if.ready = 1'b1;

  lpfd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_if.valid),
    .up_ready (in_if.ready),
    .up_byte  (in_if.stream_byte),
    .item     (item),
    .take     (take)
  );

  lpfd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item),
    .take      (take),
    .cfg_we    (cfg_if.valid),
    .cfg_data  (cfg_if.max_frame_len),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (out_if.ready)
  );

  assign out_if.valid         = res_valid;
  assign out_if.result_kind   = res.result_kind;
  assign out_if.data_byte     = res.data_byte;
  assign out_if.frame_len     = res.frame_len;
  assign out_if.last_of_frame = res.last_of_frame;
  assign out_if.error_code    = res.error_code;

endmodule

`default_nettype wire

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb: length-prefixed frame deframer testbench
// Drives byte streams of framed data through the deframer, with random
// gaps on both channels, limit writes between runs of frames and one
// long output stall. Every result is checked against an in-bench parser
// or, for the directed first frame, a table entry. The run ends on one
// error or an oversized open frame, since errors stay latched until reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import lpfd_pkg::*;

  localparam int          NUM_PHASES    = 6;
  localparam int          PHASE_ITEMS   = 320;
  localparam int          SQUEEZE_PHASE = 2;
  localparam int          CALM_PHASE    = 3;
  localparam int          SQUEEZE_LEN   = 300;
  // magic bytes in stream order, lowest byte first
  localparam logic [31:0] SYNC_WORD     = 32'h3153_5056;

  typedef enum int {
    TAIL_TOO_LONG,
    TAIL_TOO_SHORT,
    TAIL_BAD_MAGIC,
    TAIL_BOTH_FAIL,
    TAIL_HUGE_FRAME
  } tail_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    result_t    want;
  } row_t;

  logic clk;
  logic rst_n;

  lpfd_in_if  in_ch();
  lpfd_out_if out_ch();
  lpfd_cfg_if cfg_ch();

  length_prefixed_frame_deframer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // parser state mirrored from the block
  phase_t      parse_phase;
  logic [31:0] parse_count;
  logic [31:0] parse_len;
  logic [31:0] len_limit;
  logic [1:0]  latched_err;

  result_t    due_results[$];
  logic [7:0] stream_plan[$];
  row_t       dir_rows[$];
  logic [31:0] phase_limit[NUM_PHASES];

  bit calm;
  bit squeeze_req;
  int bad_results;
  int checked_results;
  int frames_opened;
  int bytes_in;
  int limit_writes;
  int squeezes;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("tb: errors");
    $finish;
  end

  function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
    logic [1:0] pos;
    r = '0;
    if (latched_err != ERR_NONE) return 1'b0;
    pos = parse_count[1:0];
    case (parse_phase)
      PH_MAGIC: begin
        if (b != SYNC_WORD[8*pos +: 8]) begin
          latched_err   = ERR_BAD_MAGIC;
          r.result_kind = KIND_ERROR;
          r.error_code  = ERR_BAD_MAGIC;
          return 1'b1;
        end
        if (pos != 2'd3) begin
          parse_count = {30'd0, pos} + 32'd1;
          return 1'b0;
        end
        parse_phase   = PH_BODY;
        parse_count   = parse_len - MAGIC_LEN;
        r.result_kind = KIND_START;
        r.frame_len   = parse_len;
        return 1'b1;
      end
      PH_BODY: begin
        if (parse_count != 0) parse_count = parse_count - 32'd1;
        if (parse_count == 0) begin
          r.last_of_frame = 1'b1;
          parse_phase     = PH_LEN;
          parse_len       = '0;
        end
        r.result_kind = KIND_BYTE;
        r.data_byte   = b;
        return 1'b1;
      end
      default: begin
        if (pos == 2'd0) parse_len = '0;
        parse_len = parse_len | ({24'd0, b} << (8*pos));
        if (pos != 2'd3) begin
          parse_phase = PH_LEN;
          parse_count = {30'd0, pos} + 32'd1;
          return 1'b0;
        end
        parse_count = '0;
        // too long wins when both checks fail
        if (parse_len > len_limit) begin
          latched_err   = ERR_TOO_LONG;
          r.result_kind = KIND_ERROR;
          r.error_code  = ERR_TOO_LONG;
          return 1'b1;
        end
        if (parse_len < MIN_FRAME_LEN) begin
          latched_err   = ERR_TOO_SHORT;
          r.result_kind = KIND_ERROR;
          r.error_code  = ERR_TOO_SHORT;
          return 1'b1;
        end
        parse_phase = PH_MAGIC;
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void flag_result(input string why, input result_t want,
                                      input result_t got);
    bad_results++;
    if (bad_results <= 10)
      $display("%0t %s: want kind %0d data %h len %h last %0d err %0d",
               $realtime, why, want.result_kind, want.data_byte, want.frame_len,
               want.last_of_frame, want.error_code,
               "\n    got kind %0d data %h len %h last %0d err %0d",
               got.result_kind, got.data_byte, got.frame_len,
               got.last_of_frame, got.error_code);
  endfunction

  function automatic void add_row(input logic [7:0] b, input bit typed,
                                  input result_t want);
    row_t row;
    row.b     = b;
    row.typed = typed;
    row.want  = want;
    dir_rows = {dir_rows, row};
  endfunction

  function automatic void plan_len_bytes(input logic [31:0] flen);
    for (int i = 0; i < 4; i++) stream_plan = {stream_plan, flen[8*i +: 8]};
  endfunction

  function automatic void plan_magic();
    for (int i = 0; i < 4; i++) stream_plan = {stream_plan, SYNC_WORD[8*i +: 8]};
  endfunction

  function automatic void plan_frame(input logic [31:0] flen);
    plan_len_bytes(flen);
    plan_magic();
    for (int i = 4; i < flen; i++)
      stream_plan = {stream_plan, 8'($urandom_range(0, 255))};
  endfunction

  function automatic logic [31:0] pick_len(input logic [31:0] cap);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return cap;
    if (roll < 20) return $urandom_range(MIN_FRAME_LEN, cap);
    return $urandom_range(MIN_FRAME_LEN, (cap < 24) ? cap : 24);
  endfunction

  task automatic push_byte(input logic [7:0] b, input bit typed, input result_t want);
    result_t r;
    bit      got;
    while (!calm && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.stream_byte <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    got = deframe_byte(b, r);
    if (typed) due_results = {due_results, want};
    else if (got) due_results = {due_results, r};
    bytes_in++;
  endtask

  task automatic send_plan(input int budget, input bit to_empty);
    int sent;
    logic [7:0] b;
    sent = 0;
    while ((sent < budget || to_empty) && stream_plan.size() != 0) begin
      b = stream_plan.pop_front();
      push_byte(b, 1'b0, '0);
      sent++;
    end
  endtask

  // wait until the block has nothing left in flight
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    cfg_ch.valid         <= 1'b1;
    cfg_ch.max_frame_len <= v;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    len_limit = v;
    limit_writes++;
  endtask

  // result side: random back-pressure, one long hold-off on request
  initial begin : result_sink
    result_t got;
    result_t want;
    int      hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = '{out_ch.result_kind, out_ch.data_byte, out_ch.frame_len,
                out_ch.last_of_frame, out_ch.error_code};
        if (due_results.size() == 0) begin
          flag_result("result with nothing due", '0, got);
        end else begin
          want = due_results.pop_front();
          if (got.result_kind !== want.result_kind || got.data_byte !== want.data_byte ||
              got.frame_len !== want.frame_len ||
              got.last_of_frame !== want.last_of_frame ||
              got.error_code !== want.error_code)
            flag_result("result mismatch", want, got);
          checked_results++;
          if (got.result_kind == KIND_START) frames_opened++;
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold_left   = SQUEEZE_LEN;
        squeezes++;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 17) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin : stimulus
    logic [31:0] cap;
    logic [31:0] lim;
    logic [31:0] flen;
    logic [7:0]  bad;
    int unsigned k;
    tail_t       tail;

    in_ch.valid          <= 1'b0;
    in_ch.stream_byte    <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.max_frame_len <= '0;
    rst_n                <= 1'b0;
    parse_phase = PH_LEN;
    parse_count = '0;
    parse_len   = '0;
    len_limit   = MAX_LEN_DEFAULT;
    latched_err = ERR_NONE;
    calm        = 1'b0;
    squeeze_req = 1'b0;

    // shortest legal frame with extreme body bytes, then a length-9 frame
    add_row(8'h08, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h56, 1'b0, '0);
    add_row(8'h50, 1'b0, '0);
    add_row(8'h53, 1'b0, '0);
    add_row(8'h31, 1'b1, '{KIND_START, 8'h00, 32'd8, 1'b0, ERR_NONE});
    add_row(8'h00, 1'b1, '{KIND_BYTE, 8'h00, 32'd0, 1'b0, ERR_NONE});
    add_row(8'hff, 1'b1, '{KIND_BYTE, 8'hff, 32'd0, 1'b0, ERR_NONE});
    add_row(8'h5a, 1'b1, '{KIND_BYTE, 8'h5a, 32'd0, 1'b0, ERR_NONE});
    add_row(8'ha5, 1'b1, '{KIND_BYTE, 8'ha5, 32'd0, 1'b1, ERR_NONE});
    add_row(8'h09, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    add_row(8'h00, 1'b0, '0);
    for (int i = 0; i < 4; i++) add_row(SYNC_WORD[8*i +: 8], 1'b0, '0);
    for (int i = 0; i < 5; i++) add_row(8'($urandom_range(0, 255)), 1'b0, '0);

    phase_limit[0] = MAX_LEN_DEFAULT;
    phase_limit[1] = MIN_FRAME_LEN;
    phase_limit[2] = 32'hffff_ffff;
    phase_limit[3] = $urandom_range(8, 64);
    phase_limit[4] = $urandom_range(1000, 32'hffff_ffff);
    phase_limit[5] = 32'hffff_ffff;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        settle();
        write_limit(phase_limit[p]);
      end
      calm = (p == CALM_PHASE);
      if (p == SQUEEZE_PHASE) squeeze_req = 1'b1;
      // a frame may straddle the next limit write, so it must fit both limits
      cap = 200;
      if (phase_limit[p] < cap) cap = phase_limit[p];
      if (p + 1 < NUM_PHASES && phase_limit[p+1] < cap) cap = phase_limit[p+1];
      for (int sent = 0; sent < PHASE_ITEMS; ) begin
        if (stream_plan.size() == 0) plan_frame(pick_len(cap));
        sent += stream_plan.size();
        send_plan(PHASE_ITEMS - (sent - stream_plan.size()), 1'b0);
      end
      if (p == NUM_PHASES - 1) send_plan(0, 1'b1);
    end
    calm = 1'b0;

    settle();
    tail = tail_t'($urandom_range(0, 4));
    case (tail)
      TAIL_TOO_LONG: begin
        lim = $urandom_range(8, 1000);
        write_limit(lim);
        flen = $urandom;
        if (flen <= lim) flen = lim + 1 + $urandom_range(0, 1000);
        plan_len_bytes(flen);
      end
      TAIL_TOO_SHORT: begin
        plan_len_bytes($urandom_range(0, 7));
      end
      TAIL_BAD_MAGIC: begin
        plan_len_bytes($urandom_range(8, 64));
        k = $urandom_range(0, 3);
        for (int i = 0; i < k; i++) stream_plan = {stream_plan, SYNC_WORD[8*i +: 8]};
        do bad = 8'($urandom_range(0, 255)); while (bad == SYNC_WORD[8*k +: 8]);
        stream_plan = {stream_plan, bad};
      end
      TAIL_BOTH_FAIL: begin
        lim = $urandom_range(0, 6);
        write_limit(lim);
        plan_len_bytes($urandom_range(lim + 1, 7));
      end
      default: begin
        write_limit(32'hffff_ffff);
        plan_len_bytes($urandom | 32'h8000_0000);
        plan_magic();
      end
    endcase
    // bytes after an error must be dropped; an open huge frame keeps passing them
    for (int i = 0; i < 20; i++) stream_plan = {stream_plan, 8'($urandom_range(0, 255))};
    send_plan(0, 1'b1);

    settle();
    repeat (10) @(posedge clk);
    $display("summary: %0d bytes in, %0d results checked, %0d frames opened",
             bytes_in, checked_results, frames_opened);
    $display("summary: %0d limit writes, %0d long output stalls, ending %s",
             limit_writes, squeezes, tail.name());
    if (bad_results == 0 && due_results.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
